### src/fbec_pkg.sv
// Shared types, constants and saturation helpers for the filter bank echo chain.
package fbec_pkg;

  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 32;
  localparam int COEF_W   = 18;
  localparam int DAMP_W   = 17;
  localparam int DLEN_W   = 16;
  localparam int MASK_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;
  localparam int PROD_W   = 35;

  localparam int unsigned DEF_CHANNELS    = 2;
  localparam int unsigned DEF_BANDS       = 10;
  localparam int unsigned DEF_DELAY_DEPTH = 32768;

  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] RATE_HZ  = 64'd44100;
  localparam logic [63:0] LOW_CUT  = 64'd100;
  localparam logic [63:0] HIGH_CUT = 64'd10000;

  typedef enum logic [2:0] {
    REG_FILTER_EN = 3'd0,
    REG_ECHO_MODE = 3'd1,
    REG_BAND_MASK = 3'd2,
    REG_DELAY_LEN = 3'd3,
    REG_DAMPING   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ECHO_OFF   = 2'd0,
    ECHO_DELAY = 2'd1,
    ECHO_HALL  = 2'd2,
    ECHO_NONE  = 2'd3
  } echo_mode_e;

  // Echo request from the sequencer.
  typedef struct packed {
    logic                       valid;
    logic                       hall;
    logic signed [SAMPLE_W-1:0] sample;
  } echo_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] result;
  } echo_rsp_t;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STATE_W-1:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

### src/fbec_mul.sv
// Shared coefficient multiplier: registered round(a * c / 2^16), ties up.
module fbec_mul (
  input  logic                               clk_i,
  input  logic signed [fbec_pkg::STATE_W-1:0] a_i,
  input  logic        [fbec_pkg::COEF_W-1:0]  c_i,
  output logic signed [fbec_pkg::PROD_W-1:0]  p_o
);
  import fbec_pkg::*;

  logic signed [50:0] prod;
  logic signed [50:0] rnd;

  assign prod = 51'(a_i) * $signed({33'd0, c_i});
  assign rnd  = prod + 51'sd32768;

  always_ff @(posedge clk_i) begin
    p_o <= rnd[50:16];
  end

endmodule

### src/fbec_echo.sv
// Echo ring buffer with per-channel pointers and a clearing sweep after reset.
module fbec_echo #(
  parameter int unsigned CHANNELS    = fbec_pkg::DEF_CHANNELS,
  parameter int unsigned DELAY_DEPTH = fbec_pkg::DEF_DELAY_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ch_i,
  input  logic [fbec_pkg::DLEN_W-1:0]   delay_len_i,
  input  fbec_pkg::echo_req_t           req_i,
  output fbec_pkg::echo_rsp_t           rsp_o,
  output logic                          clearing_o
);
  import fbec_pkg::*;

  localparam int unsigned TOTAL = CHANNELS * DELAY_DEPTH;
  localparam int AW = $clog2(TOTAL);
  localparam int PW = $clog2(DELAY_DEPTH);
  localparam int LW = (PW + 1 > DLEN_W + 1) ? PW + 1 : DLEN_W + 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SAMPLE_W-1:0] mem [TOTAL];

  logic [PW-1:0]  pos_q [CHANNELS];
  logic [AW-1:0]  clr_addr_q;
  logic           clr_busy_q;
  logic           phase_q;
  logic           hall_q;
  logic [CW-1:0]  ch_q;
  logic signed [SAMPLE_W-1:0] s_q;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic [AW-1:0]  addr_q;
  echo_rsp_t      rsp_q;

  logic [CW-1:0]  ch_sel;
  logic [AW-1:0]  rd_addr;
  logic signed [SAMPLE_W:0] sum;
  logic signed [SAMPLE_W-1:0] mix;
  logic [LW-1:0]  len_eff;
  logic [LW-1:0]  pos_inc;
  logic [LW-1:0]  dl_ext;

  assign ch_sel  = CW'(ch_i);
  assign rd_addr = AW'(ch_sel) * AW'(DELAY_DEPTH) + AW'(pos_q[ch_sel]);
  assign sum     = {s_q[SAMPLE_W-1], s_q} + {rd_q[SAMPLE_W-1], rd_q};
  assign mix     = sum[SAMPLE_W:1];
  assign dl_ext  = LW'(delay_len_i);
  assign pos_inc = LW'(pos_q[ch_q]) + LW'(1);

  // Clamp the ring length into one to the buffer depth.
  always_comb begin
    len_eff = dl_ext;
    if (dl_ext == '0) begin
      len_eff = LW'(1);
    end else if (dl_ext > LW'(DELAY_DEPTH)) begin
      len_eff = LW'(DELAY_DEPTH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (phase_q) begin
      mem[addr_q] <= hall_q ? mix : s_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      phase_q    <= 1'b0;
      rsp_q      <= '0;
      for (int i = 0; i < int'(CHANNELS); i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      rsp_q.done <= phase_q && !req_i.valid;
      if (clr_busy_q) begin
        if (clr_addr_q == AW'(TOTAL - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + AW'(1);
        end
      end
      if (req_i.valid) begin
        phase_q <= 1'b1;
      end else if (phase_q) begin
        // Advance the pointer, wrap at the clamped length.
        phase_q       <= 1'b0;
        rsp_q.result  <= mix;
        pos_q[ch_q]   <= (pos_inc >= len_eff) ? '0 : pos_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      hall_q <= req_i.hall;
      s_q    <= req_i.sample;
      ch_q   <= ch_sel;
      addr_q <= rd_addr;
    end
  end

  assign rsp_o      = rsp_q;
  assign clearing_o = clr_busy_q;

endmodule

### src/filterbank_echo_effect_chain_top.sv
// Top level: state variable filter bank sequencer, shared multiplier and echo stage.
//
//  port group   | direction | handshake              | payload
//  -------------+-----------+------------------------+------------------------------
//  input        | in        | in_valid_i / in_stall_o | channel_i, sample_in_i
//  output       | out       | out_valid_o/ out_stall_i| sample_out_o
//  config write | in        | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_wdata_i
//
// Each sample scans the bands in turn when filtering is on; each enabled band makes
// three passes through the one shared multiplier, and the echo read and write follow.
// After reset all CHANNELS*DELAY_DEPTH words of the echo buffer (65536 by default)
// are swept to zero; input requests are held off meanwhile, config writes are not.
// A finished result waits in the output register; the next request is taken
// while it waits, but a new result holds until the output is taken.
module filterbank_echo_effect_chain_top #(
  parameter int unsigned CHANNELS    = fbec_pkg::DEF_CHANNELS,
  parameter int unsigned BANDS       = fbec_pkg::DEF_BANDS,
  parameter int unsigned DELAY_DEPTH = fbec_pkg::DEF_DELAY_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                channel_i,
  input  logic signed [fbec_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fbec_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fbec_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fbec_pkg::CFG_DAT_W-1:0]      cfg_wdata_i
);
  import fbec_pkg::*;

  localparam int BW = $clog2(BANDS);
  localparam int NS = CHANNELS * BANDS;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SCAN = 11'b00000000010,
    S_M1   = 11'b00000000100,
    S_HP   = 11'b00000001000,
    S_M2   = 11'b00000010000,
    S_BP   = 11'b00000100000,
    S_M3   = 11'b00001000000,
    S_LP   = 11'b00010000000,
    S_MIX  = 11'b00100000000,
    S_EWT  = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_e;

  // Band tuning: f = 2*sin(pi*freq/44100) with a truncating Taylor series.
  function automatic logic [COEF_W-1:0] band_coef(input int unsigned b);
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    if (b == 0) begin
      num = LOW_CUT * BANDS;
    end else if (b == BANDS - 1) begin
      num = HIGH_CUT * BANDS;
    end else begin
      num = LOW_CUT * BANDS + 64'(b) * (HIGH_CUT - LOW_CUT);
    end
    x    = (PI_Q30 * num) / (RATE_HZ * BANDS);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    sum  = (sum + 64'd4096) >> 13;
    return sum[COEF_W-1:0];
  endfunction

  logic [COEF_W-1:0] f_tab [BANDS];
  for (genvar g = 0; g < BANDS; g++) begin : g_tab
    assign f_tab[g] = band_coef(g);
  end

  // Config registers.
  logic               filt_en_q;
  logic [1:0]         echo_mode_q;
  logic [MASK_W-1:0]  band_mask_q;
  logic [DLEN_W-1:0]  delay_len_q;
  logic [DAMP_W-1:0]  damping_q;

  // Filter state, one entry per channel and band.
  logic signed [STATE_W-1:0] lp_st_q [NS];
  logic signed [STATE_W-1:0] bp_st_q [NS];

  state_e state_q, state_d;
  logic [BW-1:0]             b_q;
  logic                      ch_q;
  logic signed [STATE_W-1:0] x_q, lpd_q, bpd_q, hp_q, bp_q;
  logic signed [SAMPLE_W-1:0] res_q;
  logic                      out_valid_q;

  logic signed [STATE_W-1:0] mul_a;
  logic [COEF_W-1:0]         mul_c;
  logic signed [PROD_W-1:0]  mul_p;
  logic [SW-1:0]             idx;
  logic [15:0]               mask_ext;
  logic                      band_on;
  logic                      last_band;
  logic                      ch_ok;
  logic                      clearing;
  logic                      in_fire;
  logic                      out_free;
  logic signed [STATE_W-1:0] hp_new, bp_new, lp_new;
  logic signed [SAMPLE_W-1:0] s_sat;
  echo_req_t                 ereq;
  echo_rsp_t                 ersp;

  assign idx       = SW'(SW'(ch_q) * SW'(BANDS) + SW'(b_q));
  assign mask_ext  = 16'(band_mask_q);
  assign band_on   = mask_ext[4'(b_q)];
  assign last_band = (b_q == BW'(BANDS - 1));
  assign ch_ok     = (32'(channel_i) < CHANNELS);
  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign s_sat     = sat24(x_q);

  assign hp_new = sat32(40'(x_q) - 40'(lpd_q) - 40'(mul_p));
  assign bp_new = sat32(40'(mul_p) + 40'(bpd_q));
  assign lp_new = sat32(40'(mul_p) + 40'(lpd_q));

  // Steer the shared multiplier.
  always_comb begin
    mul_a = bpd_q;
    mul_c = COEF_W'(damping_q);
    unique case (state_q)
      S_M2:    begin mul_a = hp_q; mul_c = f_tab[b_q]; end
      S_M3:    begin mul_a = bp_q; mul_c = f_tab[b_q]; end
      default: begin mul_a = bpd_q; mul_c = COEF_W'(damping_q); end
    endcase
  end

  fbec_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .c_i   (mul_c),
    .p_o   (mul_p)
  );

  assign ereq.valid  = (state_q == S_MIX) &&
                       (echo_mode_q == ECHO_DELAY || echo_mode_q == ECHO_HALL);
  assign ereq.hall   = (echo_mode_q == ECHO_HALL);
  assign ereq.sample = s_sat;

  fbec_echo #(
    .CHANNELS    (CHANNELS),
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_echo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (ch_q),
    .delay_len_i (delay_len_q),
    .req_i       (ereq),
    .rsp_o       (ersp),
    .clearing_o  (clearing)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!ch_ok)         state_d = S_DONE;
          else if (filt_en_q) state_d = S_SCAN;
          else                state_d = S_MIX;
        end
      end
      S_SCAN: begin
        if (band_on)        state_d = S_M1;
        else if (last_band) state_d = S_MIX;
      end
      S_M1: state_d = S_HP;
      S_HP: state_d = S_M2;
      S_M2: state_d = S_BP;
      S_BP: state_d = S_M3;
      S_M3: state_d = S_LP;
      S_LP: state_d = last_band ? S_MIX : S_SCAN;
      S_MIX: state_d = ereq.valid ? S_EWT : S_DONE;
      S_EWT: begin
        if (ersp.done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      filt_en_q   <= 1'b0;
      echo_mode_q <= ECHO_DELAY;
      band_mask_q <= '0;
      delay_len_q <= 16'd22050;
      damping_q   <= 17'd43691;
      b_q         <= '0;
      for (int i = 0; i < NS; i++) begin
        lp_st_q[i] <= '0;
        bp_st_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_FILTER_EN: filt_en_q   <= cfg_wdata_i[0];
          REG_ECHO_MODE: echo_mode_q <= cfg_wdata_i[1:0];
          REG_BAND_MASK: band_mask_q <= cfg_wdata_i[MASK_W-1:0];
          REG_DELAY_LEN: delay_len_q <= cfg_wdata_i[DLEN_W-1:0];
          REG_DAMPING:   damping_q   <= cfg_wdata_i[DAMP_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        b_q <= '0;
      end else if ((state_q == S_SCAN && !band_on && !last_band) ||
                   (state_q == S_LP && !last_band)) begin
        b_q <= b_q + BW'(1);
      end
      if (state_q == S_LP) begin
        bp_st_q[idx] <= bp_q;
        lp_st_q[idx] <= lp_new;
      end
      // Drop the held result once taken; load the new one when free.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q  <= channel_i;
      x_q   <= STATE_W'(sample_in_i);
      res_q <= sample_in_i;
    end
    if (state_q == S_SCAN && band_on) begin
      lpd_q <= lp_st_q[idx];
      bpd_q <= bp_st_q[idx];
    end
    if (state_q == S_HP) hp_q <= hp_new;
    if (state_q == S_BP) bp_q <= bp_new;
    if (state_q == S_LP) begin
      if (b_q == '0)     x_q <= hp_q;
      else if (last_band) x_q <= lp_new;
      else               x_q <= bp_q;
    end
    if (state_q == S_MIX && !ereq.valid) res_q <= s_sat;
    if (state_q == S_EWT && ersp.done)   res_q <= ersp.result;
  end

  logic signed [SAMPLE_W-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) out_q <= res_q;
  end

  assign in_stall_o   = (state_q != S_IDLE) || clearing;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign cfg_ready_o  = 1'b1;

endmodule

### test/tb_filterbank_echo_effect_chain_top.sv
// Self-checking testbench for the filter bank and echo chain: directed and random sample traffic.
module tb_filterbank_echo_effect_chain_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fbec_pkg::*;

  localparam int          NCH        = 2;
  localparam int          NBANDS     = 10;
  localparam int          RING_DEPTH = 32768;
  localparam int          SETTLE     = 100;      // settling wait after the last result
  localparam longint      CYCLE_LIMIT = 4000000;
  localparam int          RANDOM_PHASES = 10;
  localparam int          ITEMS_PER_PHASE = 125;
  // Indexes past the register file: writes there must do nothing.
  localparam logic [2:0]  REG_SPARE_LO = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         channel_i = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_in_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_out_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]         cfg_wdata_i = '0;

  filterbank_echo_effect_chain_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .channel_i, .sample_in_i,
    .out_valid_o, .out_stall_i, .sample_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the block: configuration, filter delays, coefficients, echo ring.
  logic                        sh_filter_en;
  logic [1:0]                  sh_echo_mode;
  logic [MASK_W-1:0]           sh_band_mask;
  logic [DLEN_W-1:0]           sh_delay_len;
  logic [DAMP_W-1:0]           sh_damping;
  logic signed [STATE_W-1:0]   lp_mem [NCH][NBANDS];
  logic signed [STATE_W-1:0]   bp_mem [NCH][NBANDS];
  logic [COEF_W-1:0]           band_coef [NBANDS];
  logic signed [SAMPLE_W-1:0]  ring_mem [NCH*RING_DEPTH];
  int unsigned                 ring_pos [NCH];

  logic signed [SAMPLE_W-1:0]  pending_out [$];
  longint                      cycle_count = 0;
  int                          mismatches = 0;
  int                          outputs_checked = 0;
  int                          samples_sent = 0;
  int                          burst_left = 0;

  typedef struct {
    logic                       ch;
    logic signed [SAMPLE_W-1:0] smp;
    bit                         known;   // expected value typed in below
    logic signed [SAMPLE_W-1:0] expv;
  } vec_t;

  // Reset settings: filter off, plain delay, empty ring, so out = floor(in/2).
  vec_t directed [] = '{
    '{1'b0, 24'sd0,        1'b1, 24'sd0},
    '{1'b1, 24'sh7fffff,   1'b1, 24'sd4194303},
    '{1'b0, 24'sh800000,   1'b1, -24'sd4194304},
    '{1'b1, -24'sd1,       1'b1, -24'sd1},
    '{1'b0, 24'sd1,        1'b1, 24'sd0},
    '{1'b1, -24'sd2,       1'b1, -24'sd1},
    '{1'b0, 24'sh555555,   1'b1, 24'sh2aaaaa},
    '{1'b1, 24'shaaaaaa,   1'b0, '0},
    '{1'b0, 24'sh7ffffe,   1'b1, 24'sd4194303},
    '{1'b1, 24'sh800001,   1'b1, -24'sd4194304},
    '{1'b0, 24'sd1000,     1'b1, 24'sd500},
    '{1'b1, -24'sd1001,    1'b1, -24'sd501}
  };

  // f = 2*sin(pi*freq/44100) by a truncating Taylor series in Q2.30.
  function automatic logic [COEF_W-1:0] tune_coef(input int b);
    longint unsigned num, x, x2, term, acc;
    if (b == 0) num = 64'd100 * NBANDS;
    else if (b == NBANDS - 1) num = 64'd10000 * NBANDS;
    else num = 64'd100 * NBANDS + longint'(b) * 64'd9900;
    x = (64'd3373259426 * num) / (64'd44100 * NBANDS);
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return COEF_W'((acc + 64'd4096) >> 13);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round to nearest, ties up.
  function automatic longint scale_q16(input longint a, input longint unsigned c);
    return (a * longint'(c) + 64'sd32768) >>> 16;
  endfunction

  function automatic void model_reset();
    sh_filter_en = 1'b0;
    sh_echo_mode = ECHO_DELAY;
    sh_band_mask = '0;
    sh_delay_len = 16'd22050;
    sh_damping   = 17'd43691;
    for (int c = 0; c < NCH; c++) begin
      ring_pos[c] = 0;
      for (int b = 0; b < NBANDS; b++) begin
        lp_mem[c][b] = '0;
        bp_mem[c][b] = '0;
      end
    end
    for (int b = 0; b < NBANDS; b++) band_coef[b] = tune_coef(b);
    for (int i = 0; i < NCH * RING_DEPTH; i++) ring_mem[i] = '0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_and_echo(
      input logic ch, input logic signed [SAMPLE_W-1:0] smp);
    longint x, hp, bp, lp, lo_d, bd_d;
    logic signed [SAMPLE_W-1:0] s, mixed, d;
    int unsigned len, pos, slot;
    int total;
    x = smp;
    if (sh_filter_en) begin
      for (int b = 0; b < NBANDS; b++) begin
        if (sh_band_mask[b]) begin
          lo_d = lp_mem[ch][b];
          bd_d = bp_mem[ch][b];
          hp = clip32(x - lo_d - scale_q16(bd_d, sh_damping));
          bp = clip32(scale_q16(hp, band_coef[b]) + bd_d);
          lp = clip32(scale_q16(bp, band_coef[b]) + lo_d);
          bp_mem[ch][b] = STATE_W'(bp);
          lp_mem[ch][b] = STATE_W'(lp);
          x = (b == 0) ? hp : (b == NBANDS - 1) ? lp : bp;
        end
      end
    end
    s = (x > 8388607) ? 24'sh7fffff : (x < -8388608) ? 24'sh800000 : SAMPLE_W'(x);
    mixed = s;
    if (sh_echo_mode == ECHO_DELAY || sh_echo_mode == ECHO_HALL) begin
      len = sh_delay_len;
      if (len < 1) len = 1;
      if (len > RING_DEPTH) len = RING_DEPTH;
      pos = ring_pos[ch];
      if (pos >= RING_DEPTH) pos = 0;
      slot = ch * RING_DEPTH + pos;
      d = ring_mem[slot];
      total = int'(s) + int'(d);
      mixed = SAMPLE_W'(total >>> 1);
      ring_mem[slot] = (sh_echo_mode == ECHO_DELAY) ? s : mixed;
      pos++;
      if (pos >= len) pos = 0;
      ring_pos[ch] = pos;
    end
    return mixed;
  endfunction

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stall: switch between no stall, light, periodic and heavy stalling.
  int unsigned stall_style = 0;
  int unsigned stall_timer = 0;
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= stall_timer[2];
      default: out_stall_i <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // Check every accepted output against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out.size() == 0) begin
        $error("sample_out with nothing expected: actual %0d", sample_out_o);
        mismatches++;
      end else begin
        logic signed [SAMPLE_W-1:0] want;
        want = pending_out.pop_front();
        outputs_checked++;
        if (sample_out_o !== want) begin
          $error("sample_out mismatch: expected %0d actual %0d", want, sample_out_o);
          mismatches++;
        end
      end
    end
  end

  // Hand one request to the block; open a new burst after a random gap.
  task automatic send_sample(input logic ch, input logic signed [SAMPLE_W-1:0] smp,
                             input bit known, input logic signed [SAMPLE_W-1:0] expv);
    int gap;
    logic signed [SAMPLE_W-1:0] pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    sample_in_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    pred = filter_and_echo(ch, smp);
    pending_out.push_back(known ? expv : pred);
    samples_sent++;
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // Hold the sender until every expected output has drained, then let the block settle.
  task automatic drain();
    if (burst_left != 0) in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_FILTER_EN: sh_filter_en = val[0];
      REG_ECHO_MODE: sh_echo_mode = val[1:0];
      REG_BAND_MASK: sh_band_mask = val[MASK_W-1:0];
      REG_DELAY_LEN: sh_delay_len = val[DLEN_W-1:0];
      REG_DAMPING:   sh_damping   = val[DAMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic fe, input logic [1:0] em, input logic [MASK_W-1:0] bm,
                           input logic [DLEN_W-1:0] dl, input logic [DAMP_W-1:0] dp);
    write_reg(REG_FILTER_EN, {16'($urandom), fe});
    write_reg(REG_ECHO_MODE, {15'($urandom), em});
    write_reg(REG_BAND_MASK, {7'($urandom), bm});
    write_reg(REG_DELAY_LEN, {1'($urandom), dl});
    write_reg(REG_DAMPING, dp);
    // Spare index: must leave every register alone.
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CFG_DAT_W'($urandom));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      1, 2:    return SAMPLE_W'($signed($urandom_range(0, 4000)) - 2000);
      3, 4:    return SAMPLE_W'($signed($urandom_range(0, 200000)) - 100000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) send_sample(1'($urandom), pick_sample(), 1'b0, '0);
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings; the first requests wait out the ring clearing sweep.
    foreach (directed[i]) send_sample(directed[i].ch, directed[i].smp,
                                      directed[i].known, directed[i].expv);
    drain();

    // Every band, hall feedback, length one, no damping.
    write_all(1'b1, ECHO_HALL, 10'h3ff, 16'd1, 17'd0);
    random_run(ITEMS_PER_PHASE);
    drain();
    // High-pass band only, zero length clamps to one, full damping.
    write_all(1'b1, ECHO_DELAY, 10'h001, 16'd0, 17'h1ffff);
    random_run(ITEMS_PER_PHASE);
    drain();
    // Low-pass band, unused echo mode, length beyond the ring.
    write_all(1'b1, ECHO_NONE, 10'h200, 16'hffff, 17'd43691);
    random_run(ITEMS_PER_PHASE);
    drain();
    // Filter off, full ring, pointers run well ahead.
    write_all(1'b0, ECHO_DELAY, 10'h155, 16'd32768, 17'd1);
    random_run(ITEMS_PER_PHASE);
    drain();
    // Shrink the ring below both pointers.
    write_reg(REG_DELAY_LEN, 17'd3);
    random_run(ITEMS_PER_PHASE);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_all(1'($urandom), 2'($urandom), 10'($urandom),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64)),
                17'($urandom));
      random_run(ITEMS_PER_PHASE - 25);
      drain();
    end

    $display("Sent %0d samples over directed, corner and random settings; %0d outputs checked.",
             samples_sent, outputs_checked);
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/fbec_pkg.sv
src/fbec_mul.sv
src/fbec_echo.sv
src/filterbank_echo_effect_chain_top.sv
test/tb_filterbank_echo_effect_chain_top.sv
